FILE: sv/irm_pkg.sv
// shared types and constants of the i2c register access master
package irm_pkg;

    localparam int unsigned IN_DATA_W   = 32;
    localparam int unsigned OUT_DATA_W  = 24;
    localparam int unsigned HALF_W      = 8;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned RESULT_W    = 21;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = 1;
    localparam int unsigned CNT_W       = 2;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd50;

    // operation codes of a command item
    localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
    localparam logic [1:0] OP_READ_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ_WORD  = 2'd2;

    // one classified input item as it sits in the queue
    typedef struct packed {
        logic              is_tick;
        logic              cmd_ok;
        logic [1:0]        op;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_idx;
        logic [BYTE_W-1:0] wr_val;
        logic              sda_sample;
    } item_t;

    // one result item, scl in the lowest bit
    typedef struct packed {
        logic              ack_error;
        logic [WORD_W-1:0] read_data;
        logic              done;
        logic              busy;
        logic              sda;
        logic              scl;
    } result_t;

endpackage

FILE: sv/irm_front.sv
// input side: accepts stream items, classifies them and queues them for the bus engine
module irm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // operation[1:0], device_address[9:2], register_index[17:10],
    // write_value[25:18], sda_sample[26], zero fill[31:27]
    input  logic [31:0]     s_axis_tdata,
    // kind[0]
    input  logic            s_axis_tuser,
    output logic            item_valid,
    output irm_pkg::item_t  item,
    input  logic            item_pop
);
    import irm_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    item_t             in_item;
    logic              push;

    // classify: a command only counts when its operation has a meaning
    always_comb
    begin
        in_item.is_tick    = s_axis_tuser;
        in_item.op         = s_axis_tdata[1:0];
        in_item.dev_addr   = s_axis_tdata[9:2];
        in_item.reg_idx    = s_axis_tdata[17:10];
        in_item.wr_val     = s_axis_tdata[25:18];
        in_item.sda_sample = s_axis_tdata[26];
        in_item.cmd_ok     = !s_axis_tuser && (s_axis_tdata[1:0] == OP_WRITE_BYTE
                              || s_axis_tdata[1:0] == OP_READ_BYTE
                              || s_axis_tdata[1:0] == OP_READ_WORD);
    end

    assign s_axis_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (count_reg != '0);
    assign item          = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !item_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && item_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && !push && count_reg == CNT_W'(1)) |=> !item_valid)
        else $error("queue not empty after last entry taken");

endmodule

FILE: sv/irm_back.sv
// bus engine: runs i2c phases one item a cycle unless stalled, registers the result
module irm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [irm_pkg::HALF_W-1:0]     cfg_data,
    input  logic                           item_valid,
    input  irm_pkg::item_t                 item,
    output logic                           item_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [irm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import irm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START, PH_ADDRW, PH_ACK1, PH_REG, PH_ACK2, PH_DATA, PH_ACK3,
        PH_RESTART, PH_ADDRR, PH_ACK4, PH_LEAD1, PH_RD1, PH_MACK, PH_LEAD2, PH_RD2,
        PH_NACK, PH_STOP
    } phase_t;

    logic [HALF_W-1:0] half_period_reg;
    phase_t            phase_reg, phase_next;
    logic [3:0]        bit_count_reg, bit_count_next;
    logic [HALF_W-1:0] hold_reg, hold_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] read_word_reg, read_word_next;
    logic [1:0]        pending_reg, pending_next;
    logic [BYTE_W-1:0] latched_addr_reg, latched_addr_next;
    logic [BYTE_W-1:0] latched_reg_reg, latched_reg_next;
    logic [BYTE_W-1:0] latched_val_reg, latched_val_next;
    logic              ack_reg, ack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              done;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           res;
    phase_t            after;
    logic [1:0]        lv;

    // index of the last segment of each phase
    function automatic logic [3:0] last_seg(phase_t ph);
        logic [3:0] n;
        case (ph)
            PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR, PH_RD1, PH_RD2: n = 4'd15;
            PH_RESTART, PH_STOP:                                 n = 4'd2;
            PH_LEAD1, PH_LEAD2:                                  n = 4'd0;
            default:                                             n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic phase_t phase_after(phase_t ph, logic [1:0] op);
        phase_t n;
        case (ph)
            PH_START:   n = PH_ADDRW;
            PH_ADDRW:   n = PH_ACK1;
            PH_ACK1:    n = PH_REG;
            PH_REG:     n = PH_ACK2;
            PH_ACK2:    n = (op == OP_WRITE_BYTE) ? PH_DATA : PH_RESTART;
            PH_DATA:    n = PH_ACK3;
            PH_ACK3:    n = PH_STOP;
            PH_RESTART: n = PH_ADDRR;
            PH_ADDRR:   n = PH_ACK4;
            PH_ACK4:    n = PH_LEAD1;
            PH_LEAD1:   n = PH_RD1;
            PH_RD1:     n = (op == OP_READ_WORD) ? PH_MACK : PH_NACK;
            PH_MACK:    n = PH_LEAD2;
            PH_LEAD2:   n = PH_RD2;
            PH_RD2:     n = PH_NACK;
            PH_NACK:    n = PH_STOP;
            default:    n = PH_IDLE;
        endcase
        return n;
    endfunction

    // pin levels {scl, sda} for a segment; lead phases keep what is on the bus
    function automatic logic [1:0] levels_of(phase_t ph, logic [3:0] bc,
                                             logic [BYTE_W-1:0] sh, logic [1:0] cur);
        logic [1:0] l;
        l = cur;
        case (ph)
            PH_START:                              l = {1'b1, bc == 4'd0};
            PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR:   l = {bc[0], sh[~bc[3:1]]};
            PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4,
            PH_NACK, PH_RD1, PH_RD2:               l = {bc[0], 1'b1};
            PH_MACK:                               l = {bc[0], 1'b0};
            PH_RESTART:                            l = {bc != 4'd0, bc != 4'd2};
            PH_STOP:                               l = {bc != 4'd0, bc == 4'd2};
            default:                               l = cur;
        endcase
        return l;
    endfunction

    assign cfg_ready = 1'b1;
    assign item_pop  = item_valid && (!out_valid_reg || m_axis_tready);
    assign after     = phase_after(phase_reg, pending_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        hold_next         = hold_reg;
        shift_next        = shift_reg;
        read_word_next    = read_word_reg;
        pending_next      = pending_reg;
        latched_addr_next = latched_addr_reg;
        latched_reg_next  = latched_reg_reg;
        latched_val_next  = latched_val_reg;
        ack_next          = ack_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        done              = 1'b0;
        lv                = {scl_reg, sda_reg};

        if (!item.is_tick)
        begin
            if (phase_reg == PH_IDLE && item.cmd_ok)
            begin
                pending_next      = item.op;
                latched_addr_next = item.dev_addr;
                latched_reg_next  = item.reg_idx;
                latched_val_next  = item.wr_val;
                ack_next          = 1'b0;
                read_word_next    = '0;
                phase_next        = PH_START;
                bit_count_next    = '0;
                hold_next         = half_period_reg;
                scl_next          = 1'b1;
                sda_next          = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (hold_reg > HALF_W'(1))
            begin
                hold_next = hold_reg - 1'b1;
            end
            else
            begin
                // sample at the end of a clock-high segment
                if (bit_count_reg[0])
                begin
                    case (phase_reg)
                        PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4:
                            ack_next = ack_reg | item.sda_sample;
                        PH_RD1, PH_RD2:
                            read_word_next = {read_word_reg[WORD_W-2:0], item.sda_sample};
                        default: ;
                    endcase
                end
                if (bit_count_reg != last_seg(phase_reg))
                begin
                    bit_count_next = bit_count_reg + 1'b1;
                    hold_next      = half_period_reg;
                    lv = levels_of(phase_reg, bit_count_next, shift_reg, {scl_reg, sda_reg});
                    scl_next = lv[1];
                    sda_next = lv[0];
                end
                else if (after == PH_IDLE)
                begin
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                    hold_next      = '0;
                    scl_next       = 1'b1;
                    sda_next       = 1'b1;
                    done           = 1'b1;
                end
                else
                begin
                    phase_next     = after;
                    bit_count_next = '0;
                    hold_next      = half_period_reg;
                    case (after)
                        PH_ADDRW: shift_next = latched_addr_reg;
                        PH_REG:   shift_next = latched_reg_reg;
                        PH_DATA:  shift_next = latched_val_reg;
                        PH_ADDRR: shift_next = latched_addr_reg | BYTE_W'(1);
                        default:  shift_next = shift_reg;
                    endcase
                    lv = levels_of(after, 4'd0, shift_next, {scl_reg, sda_reg});
                    scl_next = lv[1];
                    sda_next = lv[0];
                end
            end
        end

        res.scl       = scl_next;
        res.sda       = sda_next;
        res.busy      = (phase_next != PH_IDLE);
        res.done      = done;
        res.read_data = done ? read_word_next : '0;
        res.ack_error = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= HALF_PERIOD_RESET;
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            hold_reg         <= '0;
            shift_reg        <= '0;
            read_word_reg    <= '0;
            pending_reg      <= OP_WRITE_BYTE;
            latched_addr_reg <= '0;
            latched_reg_reg  <= '0;
            latched_val_reg  <= '0;
            ack_reg          <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                half_period_reg <= cfg_data;
            end
            if (item_pop)
            begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                hold_reg         <= hold_next;
                shift_reg        <= shift_next;
                read_word_reg    <= read_word_next;
                pending_reg      <= pending_next;
                latched_addr_reg <= latched_addr_next;
                latched_reg_reg  <= latched_reg_next;
                latched_val_reg  <= latched_val_next;
                ack_reg          <= ack_next;
                scl_reg          <= scl_next;
                sda_reg          <= sda_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), out_res_reg};

    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bit_count_reg == 4'd0 && scl_reg && sda_reg)
        else $error("idle with bus not released");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg.busy == (phase_reg != PH_IDLE))
        else $error("held result disagrees with engine state");

    a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && !item.is_tick && phase_reg != PH_IDLE)
        |=> $stable(latched_addr_reg) && $stable(pending_reg))
        else $error("command taken while busy");

endmodule

FILE: sv/i2c_register_access_master_unit.sv
// top level of the i2c register access master
// usage:
//  - s_axis carries one item per transfer; tuser is the kind (0 command,
//    1 tick). a command starts a write byte, read byte or read word
//    transaction when the engine is idle and the code is known, else is dropped; a tick
//    advances the bus by one time step and brings the sampled sda level
//  - m_axis returns exactly one result per input item, in order: pin levels,
//    busy, done, read data (valid with done) and the sticky ack error
//  - cfg writes half_period (ticks per pin segment) with no transfer in
//    flight; during a transaction it counts from the next pin segment
// timing:
//  - a new transfer is accepted every clock while the output is not stalled;
//    an accepted item passes the two-entry input queue, and its result is
//    registered in the output register that drives m_axis
//  - the input queue parts the two sides, so the input keeps flowing while a
//    finished result waits on m_axis_tready, until the queue is full
// reset:
//  - rst_n clears the queue and output, puts the engine idle with both lines
//    released and half_period back to 50
// stall:
//  - while m_axis_tready is low the held result stays put and the engine
//    stops; s_axis_tready falls once both queue entries are full
module i2c_register_access_master_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], device_address[9:2], register_index[17:10],
    // write_value[25:18], sda_sample[26], zero fill[31:27]
    input  logic [31:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_released[0], sda_released[1], busy_res[2], done_res[3],
    // read_data[19:4], ack_error[20], zero fill[23:21]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    // half_period[7:0]
    input  logic [7:0]  cfg_data
);
    import irm_pkg::*;

    item_t item;
    logic  item_valid;
    logic  item_pop;

    // front: classify items and queue them
    irm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // back: phase sequencer, pin levels and result register
    irm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: tb/sv/i2c_register_access_master_unit_tb.sv
// self-checking testbench of the i2c register access master, predicting every result item
module i2c_register_access_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irm_pkg::*;

    // item kinds on tuser
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;
    // the one operation code with no meaning, dropped by the block
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // odds, in eighths, that a sampled acknowledge or data bit is high
    localparam int ALWAYS_LOW  = 0;
    localparam int RARELY_HIGH = 1;
    localparam int EVEN_ODDS   = 4;
    localparam int ALWAYS_HIGH = 8;

    localparam int MAX_WAIT      = 19;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLDOFF_LEN   = 300;
    localparam int RANDOM_ITEMS  = 450;
    localparam int REPORT_CAP    = 100;
    localparam int CYCLE_LIMIT   = 4_000_000;
    // ticks spent in the first segment before the half period drops to one
    localparam int EARLY_TICKS   = 40;
    localparam int LONG_TICKS    = 200;
    // ticks that carry any transaction of write length through its stop
    // at a half period of one, on top of the rest of a longer segment
    localparam int FINISH_TICKS  = 64;

    // bus phases of the transaction engine
    typedef enum logic [4:0] {
        BP_IDLE, BP_START, BP_ADDR_WR, BP_ACK_ADDR_WR, BP_REG, BP_ACK_REG,
        BP_DATA, BP_ACK_DATA, BP_RESTART, BP_ADDR_RD, BP_ACK_ADDR_RD,
        BP_LEAD_FIRST, BP_READ_FIRST, BP_MASTER_ACK, BP_LEAD_SECOND,
        BP_READ_SECOND, BP_MASTER_NACK, BP_STOP
    } bus_phase_t;

    // one input item before packing
    typedef struct {
        logic       kind;
        logic [1:0] op;
        logic [7:0] dev_addr;
        logic [7:0] reg_index;
        logic [7:0] value;
        logic       sda;
    } bus_item_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operation[1:0], device_address[9:2], register_index[17:10],
    // write_value[25:18], sda_sample[26], zero fill[31:27]
    logic [31:0] s_axis_tdata  = '0;
    // kind[0]
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // scl_released[0], sda_released[1], busy_res[2], done_res[3],
    // read_data[19:4], ack_error[20], zero fill[23:21]
    logic [23:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    // half_period[7:0]
    logic [7:0]  cfg_data      = '0;

    i2c_register_access_master_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bus engine predictor, own copy of state and of half_period
    // ------------------------------------------------------------------
    logic [7:0]  cur_half  = HALF_PERIOD_RESET;
    bus_phase_t  bus_phase = BP_IDLE;
    logic [3:0]  seg_idx   = '0;
    logic [7:0]  hold_left = '0;
    logic [7:0]  out_byte  = '0;
    logic [15:0] in_word   = '0;
    logic [1:0]  txn_op    = '0;
    logic [7:0]  txn_addr  = '0;
    logic [7:0]  txn_reg   = '0;
    logic [7:0]  txn_val   = '0;
    logic        nack_seen = 1'b0;
    logic        scl_lvl   = 1'b1;
    logic        sda_lvl   = 1'b1;

    function automatic bit sends_byte(bus_phase_t p);
        return p == BP_ADDR_WR || p == BP_REG || p == BP_DATA || p == BP_ADDR_RD;
    endfunction

    function automatic bit slave_acks(bus_phase_t p);
        return p == BP_ACK_ADDR_WR || p == BP_ACK_REG || p == BP_ACK_DATA
            || p == BP_ACK_ADDR_RD;
    endfunction

    function automatic bit reads_byte(bus_phase_t p);
        return p == BP_READ_FIRST || p == BP_READ_SECOND;
    endfunction

    // pin segments making up one phase
    function automatic int segment_count(bus_phase_t p);
        if (sends_byte(p) || reads_byte(p))
            return 16;
        if (p == BP_RESTART || p == BP_STOP)
            return 3;
        if (p == BP_LEAD_FIRST || p == BP_LEAD_SECOND)
            return 1;
        return 2;
    endfunction

    function automatic bus_phase_t phase_following(bus_phase_t p, logic [1:0] op);
        case (p)
            BP_START:       return BP_ADDR_WR;
            BP_ADDR_WR:     return BP_ACK_ADDR_WR;
            BP_ACK_ADDR_WR: return BP_REG;
            BP_REG:         return BP_ACK_REG;
            BP_ACK_REG:     return (op == OP_WRITE_BYTE) ? BP_DATA : BP_RESTART;
            BP_DATA:        return BP_ACK_DATA;
            BP_ACK_DATA:    return BP_STOP;
            BP_RESTART:     return BP_ADDR_RD;
            BP_ADDR_RD:     return BP_ACK_ADDR_RD;
            BP_ACK_ADDR_RD: return BP_LEAD_FIRST;
            BP_LEAD_FIRST:  return BP_READ_FIRST;
            BP_READ_FIRST:  return (op == OP_READ_WORD) ? BP_MASTER_ACK : BP_MASTER_NACK;
            BP_MASTER_ACK:  return BP_LEAD_SECOND;
            BP_LEAD_SECOND: return BP_READ_SECOND;
            BP_READ_SECOND: return BP_MASTER_NACK;
            BP_MASTER_NACK: return BP_STOP;
            default:        return BP_IDLE;
        endcase
    endfunction

    // pin levels for the current phase and segment; lead phases keep them
    function automatic void set_pins();
        logic odd;
        odd = seg_idx[0];
        if (bus_phase == BP_START)
        begin
            scl_lvl = 1'b1;
            sda_lvl = (seg_idx == 4'd0);
        end
        else if (sends_byte(bus_phase))
        begin
            scl_lvl = odd;
            sda_lvl = out_byte[3'd7 - seg_idx[3:1]];
        end
        else if (slave_acks(bus_phase) || reads_byte(bus_phase)
                 || bus_phase == BP_MASTER_NACK)
        begin
            scl_lvl = odd;
            sda_lvl = 1'b1;
        end
        else if (bus_phase == BP_MASTER_ACK)
        begin
            scl_lvl = odd;
            sda_lvl = 1'b0;
        end
        else if (bus_phase == BP_RESTART)
        begin
            scl_lvl = (seg_idx != 4'd0);
            sda_lvl = (seg_idx != 4'd2);
        end
        else if (bus_phase == BP_STOP)
        begin
            scl_lvl = (seg_idx != 4'd0);
            sda_lvl = (seg_idx == 4'd2);
        end
    endfunction

    function automatic void enter_phase(bus_phase_t p);
        bus_phase = p;
        seg_idx   = '0;
        hold_left = cur_half;
        case (p)
            BP_ADDR_WR: out_byte = txn_addr;
            BP_REG:     out_byte = txn_reg;
            BP_DATA:    out_byte = txn_val;
            BP_ADDR_RD: out_byte = txn_addr | 8'h01;
            default:    ;
        endcase
        set_pins();
    endfunction

    // one time step; true when the stop has just completed
    function automatic bit bus_tick(logic sample);
        bus_phase_t nxt;
        if (bus_phase == BP_IDLE)
            return 1'b0;
        if (hold_left > 8'd1)
        begin
            hold_left--;
            return 1'b0;
        end
        // end of a clock-high segment: acknowledge or data bit is sampled
        if (seg_idx[0])
        begin
            if (slave_acks(bus_phase))
                nack_seen |= sample;
            else if (reads_byte(bus_phase))
                in_word = {in_word[14:0], sample};
        end
        if (int'(seg_idx) + 1 < segment_count(bus_phase))
        begin
            seg_idx++;
            hold_left = cur_half;
            set_pins();
            return 1'b0;
        end
        nxt = phase_following(bus_phase, txn_op);
        if (nxt == BP_IDLE)
        begin
            bus_phase = BP_IDLE;
            seg_idx   = '0;
            hold_left = '0;
            scl_lvl   = 1'b1;
            sda_lvl   = 1'b1;
            return 1'b1;
        end
        enter_phase(nxt);
        return 1'b0;
    endfunction

    function automatic result_t advance_bus(bus_item_t it);
        result_t r;
        logic    finished;
        finished = 1'b0;
        if (it.kind == KIND_COMMAND)
        begin
            // commands while busy and the reserved code are dropped
            if (bus_phase == BP_IDLE && it.op != OP_RESERVED)
            begin
                txn_op    = it.op;
                txn_addr  = it.dev_addr;
                txn_reg   = it.reg_index;
                txn_val   = it.value;
                nack_seen = 1'b0;
                in_word   = '0;
                enter_phase(BP_START);
            end
        end
        else
            finished = bus_tick(it.sda);
        r.scl       = scl_lvl;
        r.sda       = sda_lvl;
        r.busy      = (bus_phase != BP_IDLE);
        r.done      = finished;
        r.read_data = finished ? in_word : '0;
        r.ack_error = nack_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus store, expected results and run statistics
    // ------------------------------------------------------------------
    bus_item_t bus_items_to_send[$];
    result_t   expected_bus_results[$];

    int field_errors    = 0;
    int items_accepted  = 0;
    int txns_finished   = 0;
    int reads_finished  = 0;
    int nacked_finished = 0;
    int settings_used   = 0;

    // idling knobs, changed by the sequence between phases
    int tx_gap_max  = 0;
    int rx_stall_max = 0;
    int rx_holdoff  = 0;

    // input side state of the driver; offered_item and tx_taken are shared with the capture
    bus_item_t offered_item = '{default: '0};
    bit        tx_offering  = 1'b0;
    bit        tx_taken     = 1'b0;
    int        tx_gap       = 0;

    function automatic int draw_wait(int max_wait);
        return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
    endfunction

    task automatic push_tick(input logic sample);
        bus_item_t it;
        // command fields of a tick carry noise, the block must ignore them
        it.kind      = KIND_TICK;
        it.op        = 2'($urandom_range(0, 3));
        it.dev_addr  = 8'($urandom);
        it.reg_index = 8'($urandom);
        it.value     = 8'($urandom);
        it.sda       = sample;
        bus_items_to_send.push_back(it);
    endtask

    task automatic push_command(input logic [1:0] op, input logic [7:0] addr,
                                input logic [7:0] reg_no, input logic [7:0] val);
        bus_item_t it;
        it.kind      = KIND_COMMAND;
        it.op        = op;
        it.dev_addr  = addr;
        it.reg_index = reg_no;
        it.value     = val;
        it.sda       = 1'($urandom_range(0, 1));
        bus_items_to_send.push_back(it);
    endtask

    // plain ticks with random samples
    task automatic queue_ticks(input int count);
        for (int n = 0; n < count; n++)
            push_tick(1'($urandom_range(0, 1)));
    endtask

    // ticks while idle and reserved commands, none of which starts anything
    task automatic queue_idle_noise(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_command(OP_RESERVED, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                push_tick(1'($urandom_range(0, 1)));
        end
    endtask

    // a command and exactly the ticks that carry it through its stop;
    // sample ticks take the given odds, stray commands land while busy
    task automatic queue_transaction(input logic [1:0] op, input logic [7:0] addr,
                                     input logic [7:0] reg_no, input logic [7:0] val,
                                     input int ack_high, input int data_high,
                                     input bit stray_commands);
        bus_phase_t ph;
        int         ticks_per_seg;
        logic       sample;
        // a zero half period behaves as one
        ticks_per_seg = (cur_half == 8'd0) ? 1 : int'(cur_half);
        push_command(op, addr, reg_no, val);
        ph = BP_START;
        while (ph != BP_IDLE)
        begin
            for (int seg = 0; seg < segment_count(ph); seg++)
            begin
                for (int t = 0; t < ticks_per_seg; t++)
                begin
                    sample = 1'($urandom_range(0, 1));
                    if (seg % 2 == 1 && t == ticks_per_seg - 1)
                    begin
                        if (slave_acks(ph))
                            sample = (int'($urandom_range(0, 7)) < ack_high);
                        else if (reads_byte(ph))
                            sample = (int'($urandom_range(0, 7)) < data_high);
                    end
                    if (stray_commands && $urandom_range(0, 31) == 0)
                        push_command(2'($urandom_range(0, 3)), 8'($urandom),
                                     8'($urandom), 8'($urandom));
                    push_tick(sample);
                end
            end
            ph = phase_following(ph, op);
        end
    endtask

    task automatic pick_idle_modes();
        tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
        rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
    endtask

    // block idle: every item sent, every result back, pipeline flushed
    task automatic drain_and_settle();
        while (bus_items_to_send.size() != 0 || tx_offering
               || expected_bus_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_half_period(input logic [7:0] val);
        @(negedge clk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_half = val;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            field_errors++;
            if (field_errors <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // input side: driver at the falling edge, transfer capture at the rising
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : input_capture
        result_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            want = advance_bus(offered_item);
            expected_bus_results.push_back(want);
            items_accepted++;
            if (want.done)
            begin
                txns_finished++;
                if (txn_op != OP_WRITE_BYTE)
                    reads_finished++;
                if (want.ack_error)
                    nacked_finished++;
            end
            tx_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : input_driver
        if (tx_taken)
        begin
            tx_taken    = 1'b0;
            tx_offering = 1'b0;
            tx_gap      = draw_wait(tx_gap_max);
        end
        if (!tx_offering)
        begin
            if (tx_gap > 0)
                tx_gap--;
            else if (bus_items_to_send.size() != 0)
            begin
                offered_item = bus_items_to_send.pop_front();
                tx_offering  = 1'b1;
            end
        end
        // valid stays up across back-to-back transfers, one assignment per edge
        s_axis_tvalid <= tx_offering;
        s_axis_tuser  <= offered_item.kind;
        s_axis_tdata  <= {5'd0, offered_item.sda, offered_item.value,
                          offered_item.reg_index, offered_item.dev_addr, offered_item.op};
    end

    // ------------------------------------------------------------------
    // output side: ready at the falling edge, result check at the rising
    // ------------------------------------------------------------------
    bit rx_taken = 1'b0;
    int rx_stall = 0;

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got      = m_axis_tdata[RESULT_W-1:0];
            rx_taken = 1'b1;
            if (expected_bus_results.size() == 0)
            begin
                field_errors++;
                $display("%0t ns: result with none expected, expected nothing, actual %h",
                         $time, got);
            end
            else
            begin
                want = expected_bus_results.pop_front();
                check_field("scl_released", 16'(want.scl), 16'(got.scl));
                check_field("sda_released", 16'(want.sda), 16'(got.sda));
                check_field("busy_res", 16'(want.busy), 16'(got.busy));
                check_field("done_res", 16'(want.done), 16'(got.done));
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_error", 16'(want.ack_error), 16'(got.ack_error));
            end
        end
    end

    always @(negedge clk)
    begin : ready_driver
        if (rx_taken)
        begin
            rx_taken = 1'b0;
            rx_stall = draw_wait(rx_stall_max);
        end
        // the long hold-off lets the queue fill so that s_axis_tready drops
        if (rx_holdoff > 0)
        begin
            rx_holdoff--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        int          random_items;
        int          random_phases;
        int          txn_count;
        logic [1:0]  op;
        int          ack_odds;
        logic [7:0]  half;
        random_items  = 0;
        random_phases = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset half period: ticks while idle, the reserved code, then a
        // write whose first segment holds for the reset count; the half
        // period then drops to one so that the rest runs short
        push_tick(1'b1);
        push_tick(1'b0);
        push_command(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF);
        push_command(OP_WRITE_BYTE, 8'hA4, 8'h3C, 8'h5A);
        queue_ticks(EARLY_TICKS);
        drain_and_settle();
        write_half_period(8'd1);
        queue_ticks(int'(HALF_PERIOD_RESET) + FINISH_TICKS);
        drain_and_settle();

        // shortest half period: every operation with field extremes
        pick_idle_modes();
        write_half_period(8'd1);
        queue_transaction(OP_WRITE_BYTE, 8'hFE, 8'h00, 8'hFF, ALWAYS_LOW, EVEN_ODDS, 1'b0);
        queue_transaction(OP_WRITE_BYTE, 8'h00, 8'hFF, 8'h00, ALWAYS_HIGH, EVEN_ODDS, 1'b1);
        // address with its low bit already set
        queue_transaction(OP_READ_BYTE, 8'hFF, 8'hFF, 8'h00, ALWAYS_LOW, ALWAYS_HIGH, 1'b0);
        queue_transaction(OP_READ_WORD, 8'h00, 8'h80, 8'hFF, ALWAYS_HIGH, ALWAYS_LOW, 1'b1);
        queue_transaction(OP_READ_WORD, 8'h5B, 8'h01, 8'h7F, RARELY_HIGH, EVEN_ODDS, 1'b1);
        queue_idle_noise(6);
        drain_and_settle();

        // zero half period runs like one
        pick_idle_modes();
        write_half_period(8'd0);
        queue_transaction(OP_READ_WORD, 8'($urandom), 8'($urandom), 8'($urandom),
                          ALWAYS_LOW, EVEN_ODDS, 1'b1);
        queue_transaction(OP_WRITE_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                          RARELY_HIGH, EVEN_ODDS, 1'b0);
        drain_and_settle();

        // longest half period at full rate: the first segment of a write
        // holds for the full count, then the half period drops to one
        tx_gap_max   = 0;
        rx_stall_max = 0;
        write_half_period(8'd255);
        push_command(OP_WRITE_BYTE, 8'($urandom), 8'($urandom), 8'($urandom));
        queue_ticks(LONG_TICKS);
        drain_and_settle();
        write_half_period(8'd1);
        queue_ticks(255 - LONG_TICKS + FINISH_TICKS);
        drain_and_settle();

        // random part: small half periods, well-formed transactions with
        // random content, idle noise and stray commands in between
        while (random_items < RANDOM_ITEMS)
        begin
            pick_idle_modes();
            half = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(5, 12))
                                               : 8'($urandom_range(1, 4));
            write_half_period(half);
            txn_count = $urandom_range(1, 3);
            for (int n = 0; n < txn_count; n++)
            begin
                queue_idle_noise($urandom_range(0, 4));
                op = 2'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0:       ack_odds = RARELY_HIGH;
                    1:       ack_odds = EVEN_ODDS;
                    default: ack_odds = ALWAYS_LOW;
                endcase
                queue_transaction(op, 8'($urandom), 8'($urandom), 8'($urandom),
                                  ack_odds, EVEN_ODDS, 1'($urandom_range(0, 1)));
            end
            random_items += bus_items_to_send.size();
            if (random_phases == 0)
            begin
                // sender keeps offering while the receiver sits idle
                tx_gap_max = 0;
                rx_holdoff = HOLDOFF_LEN;
            end
            random_phases++;
            drain_and_settle();
        end

        $display("run covered %0d items and %0d finished transactions, %0d of them reads",
                 items_accepted, txns_finished, reads_finished);
        $display("%0d transactions saw a failed acknowledge, %0d half period settings used",
                 nacked_finished, settings_used);
        if (field_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("run stopped at the cycle limit with %0d results outstanding",
                 expected_bus_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
sv/irm_pkg.sv
sv/irm_front.sv
sv/irm_back.sv
sv/i2c_register_access_master_unit.sv
tb/sv/i2c_register_access_master_unit_tb.sv
